### rtl/core/ieu_pkg.sv
// ----------------------------------------------------------------------------
// Integer execute unit package
// Opcode and function-code constants, exception codes and the structs that
// pass operands and results between the execute datapath and the top level.
// ----------------------------------------------------------------------------
package ieu_pkg;

  // Primary opcodes (instruction bits 31..26).
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_REGIMM  = 6'h01;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_BLEZ    = 6'h06;
  localparam logic [5:0] OP_BGTZ    = 6'h07;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_SLTI    = 6'h0A;
  localparam logic [5:0] OP_SLTIU   = 6'h0B;
  localparam logic [5:0] OP_ANDI    = 6'h0C;
  localparam logic [5:0] OP_ORI     = 6'h0D;
  localparam logic [5:0] OP_XORI    = 6'h0E;
  localparam logic [5:0] OP_LUI     = 6'h0F;

  // Function codes of the SPECIAL group (instruction bits 5..0).
  localparam logic [5:0] FN_SLL     = 6'h00;
  localparam logic [5:0] FN_SRL     = 6'h02;
  localparam logic [5:0] FN_SRA     = 6'h03;
  localparam logic [5:0] FN_SLLV    = 6'h04;
  localparam logic [5:0] FN_SRLV    = 6'h06;
  localparam logic [5:0] FN_SRAV    = 6'h07;
  localparam logic [5:0] FN_JR      = 6'h08;
  localparam logic [5:0] FN_JALR    = 6'h09;
  localparam logic [5:0] FN_SYSCALL = 6'h0C;
  localparam logic [5:0] FN_BREAK   = 6'h0D;
  localparam logic [5:0] FN_ADD     = 6'h20;
  localparam logic [5:0] FN_ADDU    = 6'h21;
  localparam logic [5:0] FN_SUB     = 6'h22;
  localparam logic [5:0] FN_SUBU    = 6'h23;
  localparam logic [5:0] FN_AND     = 6'h24;
  localparam logic [5:0] FN_OR      = 6'h25;
  localparam logic [5:0] FN_XOR     = 6'h26;
  localparam logic [5:0] FN_NOR     = 6'h27;
  localparam logic [5:0] FN_SLT     = 6'h2A;
  localparam logic [5:0] FN_SLTU    = 6'h2B;

  // Branch-on-zero selectors in the rt field that also link.
  localparam logic [4:0] RT_BLTZAL  = 5'h10;
  localparam logic [4:0] RT_BGEZAL  = 5'h11;

  localparam logic [4:0] RETURN_ADDR_REG = 5'd31;

  typedef enum logic [2:0] {
    EXC_NONE      = 3'd0,
    EXC_OVERFLOW  = 3'd1,
    EXC_SYSCALL   = 3'd2,
    EXC_BREAK     = 3'd3,
    EXC_UNHANDLED = 3'd4
  } ieu_exc_t;

  typedef struct packed {
    logic [31:0] instruction;
    logic [31:0] source_value;
    logic [31:0] target_value;
    logic [31:0] next_pc;
  } ieu_operands_t;

  typedef struct packed {
    logic [31:0] result_value;
    logic [4:0]  dest_register;
    logic        write_enable;
    ieu_exc_t    exception_code;
    logic        branch_taken;
    logic [31:0] branch_target;
  } ieu_result_t;

endpackage

### rtl/core/integer_execute_unit.sv
// ----------------------------------------------------------------------------
// Integer execute unit
// Execute stage for the integer subset of a classic 32-bit load/store ISA.
// ----------------------------------------------------------------------------
// The unit takes one instruction per clock cycle while the consumer does not
// stall and returns exactly one result per instruction, in order. An accepted
// instruction is captured in an input register; a single combinational decode
// and execute pass computes its result, which loads into the output register
// once that register is free or being emptied and is then visible on the
// outputs; while the consumer does not stall a new transfer can follow
// in every cycle. Throughput is one instruction per cycle, set by
// the one pass of the execute datapath between the two registers. When the
// consumer stalls, the output register holds its result while the input
// register can still take one more instruction, so the producer sees a stall
// only once both registers are full. Shifts, add and subtract (trapping and
// wrapping), logic, set-less-than, immediate forms, LUI, conditional branches
// with their link forms and jumps are executed here. Loads, stores,
// multiply/divide, HI/LO moves, coprocessor ops, reserved opcodes and reserved
// function codes come back with the "not handled" exception code and no write
// or branch. With no register write, the value and destination read as zero,
// and the branch target reads as zero whenever no branch is taken.
// ----------------------------------------------------------------------------
module integer_execute_unit (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_instruction,
  input  logic [31:0] in_source_value,
  input  logic [31:0] in_target_value,
  input  logic [31:0] in_next_pc,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_result_value,
  output logic [4:0]  out_dest_register,
  output logic        out_write_enable,
  output logic [2:0]  out_exception_code,
  output logic        out_branch_taken,
  output logic [31:0] out_branch_target
);
  import ieu_pkg::*;

  ieu_operands_t ops_r;
  logic          in_valid_r;
  ieu_result_t   res_nxt;
  ieu_result_t   res_r;
  logic          out_valid_r;
  logic          advance;

  // The execute stage moves forward when the output register is empty or
  // its result is being transferred this cycle.
  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  // Payload registers carry no reset; they load only on a transfer.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ops_r.instruction  <= in_instruction;
      ops_r.source_value <= in_source_value;
      ops_r.target_value <= in_target_value;
      ops_r.next_pc      <= in_next_pc;
    end
    if (advance && in_valid_r) begin
      res_r <= res_nxt;
    end
  end

  ieu_exec u_exec (
    .ops (ops_r),
    .res (res_nxt)
  );

  assign out_valid          = out_valid_r;
  assign out_result_value   = res_r.result_value;
  assign out_dest_register  = res_r.dest_register;
  assign out_write_enable   = res_r.write_enable;
  assign out_exception_code = res_r.exception_code;
  assign out_branch_taken   = res_r.branch_taken;
  assign out_branch_target  = res_r.branch_target;

  // A write never targets register zero.
  a_wen_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_write_enable) |-> (out_dest_register != 5'd0))
    else $error("write enabled toward register zero");

  // Without a write the value and destination read as zero.
  a_nowrite_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_write_enable) |->
      ((out_result_value == 32'd0) && (out_dest_register == 5'd0)))
    else $error("value or destination nonzero without a write");

  // An exception suppresses both the write and the branch.
  a_exc_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_exception_code != EXC_NONE)) |->
      (!out_write_enable && !out_branch_taken))
    else $error("exception with a write or branch");

  // A buffered instruction moves into a free output register.
  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !out_valid_r) |=> out_valid_r)
    else $error("execute stage failed to advance into empty output");

endmodule

### rtl/core/ieu_exec.sv
// ----------------------------------------------------------------------------
// Integer execute datapath
// Decodes one instruction and computes its writeback, control transfer and
// exception code in a single combinational pass.
// ----------------------------------------------------------------------------
module ieu_exec (
  input  ieu_pkg::ieu_operands_t ops,
  output ieu_pkg::ieu_result_t   res
);
  import ieu_pkg::*;

  logic [5:0]  prim;
  logic [4:0]  rt;
  logic [4:0]  rd;
  logic [4:0]  sh;
  logic [5:0]  fn;
  logic [15:0] imm;
  logic [31:0] simm;
  logic [31:0] sv;
  logic [31:0] tv;
  logic [31:0] sum;
  logic [31:0] diff;
  logic [31:0] isum;
  logic        add_ovf;
  logic        sub_ovf;
  logic        addi_ovf;
  logic [31:0] btarget;
  logic [31:0] jtarget;
  logic [31:0] link;
  logic        sv_neg;

  logic [31:0] val;
  logic [4:0]  dst;
  logic        wr;
  logic        tk;
  logic [31:0] tgt;
  ieu_exc_t    exc;

  assign prim    = ops.instruction[31:26];
  assign rt      = ops.instruction[20:16];
  assign rd      = ops.instruction[15:11];
  assign sh      = ops.instruction[10:6];
  assign fn      = ops.instruction[5:0];
  assign imm     = ops.instruction[15:0];
  assign simm    = {{16{imm[15]}}, imm};
  assign sv      = ops.source_value;
  assign tv      = ops.target_value;
  assign sv_neg  = sv[31];

  assign sum     = sv + tv;
  assign diff    = sv - tv;
  assign isum    = sv + simm;
  assign add_ovf  = (sv[31] == tv[31])   && (sum[31]  != sv[31]);
  assign sub_ovf  = (sv[31] != tv[31])   && (diff[31] != sv[31]);
  assign addi_ovf = (sv[31] == simm[31]) && (isum[31] != sv[31]);

  assign btarget = ops.next_pc + {simm[29:0], 2'b00};
  assign link    = ops.next_pc + 32'd4;
  assign jtarget = {ops.next_pc[31:28], ops.instruction[25:0], 2'b00};

  always_comb begin
    val = '0;
    dst = '0;
    wr  = 1'b0;
    tk  = 1'b0;
    tgt = '0;
    exc = EXC_NONE;
    unique case (prim)
      OP_SPECIAL: begin
        dst = rd;
        wr  = 1'b1;
        unique case (fn)
          FN_SLL:  val = tv << sh;
          FN_SRL:  val = tv >> sh;
          FN_SRA:  val = $unsigned($signed(tv) >>> sh);
          FN_SLLV: val = tv << sv[4:0];
          FN_SRLV: val = tv >> sv[4:0];
          FN_SRAV: val = $unsigned($signed(tv) >>> sv[4:0]);
          FN_JR: begin
            wr  = 1'b0;
            tk  = 1'b1;
            tgt = sv;
          end
          FN_JALR: begin
            val = link;
            tk  = 1'b1;
            tgt = sv;
          end
          FN_SYSCALL: begin
            wr  = 1'b0;
            exc = EXC_SYSCALL;
          end
          FN_BREAK: begin
            wr  = 1'b0;
            exc = EXC_BREAK;
          end
          FN_ADD: begin
            if (add_ovf) begin
              wr  = 1'b0;
              exc = EXC_OVERFLOW;
            end else begin
              val = sum;
            end
          end
          FN_ADDU: val = sum;
          FN_SUB: begin
            if (sub_ovf) begin
              wr  = 1'b0;
              exc = EXC_OVERFLOW;
            end else begin
              val = diff;
            end
          end
          FN_SUBU: val = diff;
          FN_AND:  val = sv & tv;
          FN_OR:   val = sv | tv;
          FN_XOR:  val = sv ^ tv;
          FN_NOR:  val = ~(sv | tv);
          FN_SLT:  val = {31'd0, ($signed(sv) < $signed(tv))};
          FN_SLTU: val = {31'd0, (sv < tv)};
          default: begin
            wr  = 1'b0;
            exc = EXC_UNHANDLED;
          end
        endcase
      end
      OP_REGIMM: begin
        // Only the low rt bit selects the sense; the two link selectors
        // happen to share that bit with their plain counterparts.
        tk  = rt[0] ? !sv_neg : sv_neg;
        tgt = btarget;
        if ((rt == RT_BLTZAL) || (rt == RT_BGEZAL)) begin
          wr  = 1'b1;
          dst = RETURN_ADDR_REG;
          val = link;
        end
      end
      OP_J: begin
        tk  = 1'b1;
        tgt = jtarget;
      end
      OP_JAL: begin
        tk  = 1'b1;
        tgt = jtarget;
        wr  = 1'b1;
        dst = RETURN_ADDR_REG;
        val = link;
      end
      OP_BEQ: begin
        tk  = (sv == tv);
        tgt = btarget;
      end
      OP_BNE: begin
        tk  = (sv != tv);
        tgt = btarget;
      end
      OP_BLEZ: begin
        tk  = (sv == '0) || sv_neg;
        tgt = btarget;
      end
      OP_BGTZ: begin
        tk  = (sv != '0) && !sv_neg;
        tgt = btarget;
      end
      OP_ADDI: begin
        if (addi_ovf) begin
          exc = EXC_OVERFLOW;
        end else begin
          wr  = 1'b1;
          dst = rt;
          val = isum;
        end
      end
      OP_ADDIU: begin
        wr  = 1'b1;
        dst = rt;
        val = isum;
      end
      OP_SLTI: begin
        wr  = 1'b1;
        dst = rt;
        val = {31'd0, ($signed(sv) < $signed(simm))};
      end
      OP_SLTIU: begin
        wr  = 1'b1;
        dst = rt;
        val = {31'd0, (sv < simm)};
      end
      OP_ANDI: begin
        wr  = 1'b1;
        dst = rt;
        val = sv & {16'd0, imm};
      end
      OP_ORI: begin
        wr  = 1'b1;
        dst = rt;
        val = sv | {16'd0, imm};
      end
      OP_XORI: begin
        wr  = 1'b1;
        dst = rt;
        val = sv ^ {16'd0, imm};
      end
      OP_LUI: begin
        wr  = 1'b1;
        dst = rt;
        val = {imm, 16'd0};
      end
      default: exc = EXC_UNHANDLED;
    endcase

    // A write to register zero, or no write at all, shows as all zeros.
    if (!wr || (dst == '0)) begin
      wr  = 1'b0;
      dst = '0;
      val = '0;
    end
    if (!tk) begin
      tgt = '0;
    end

    res.result_value   = val;
    res.dest_register  = dst;
    res.write_enable   = wr;
    res.exception_code = exc;
    res.branch_taken   = tk;
    res.branch_target  = tgt;
  end

endmodule

### bench/integer_execute_unit_test.sv
// ----------------------------------------------------------------------------
// Integer execute unit testbench
// Sends instruction words with their operand values and delay-slot addresses
// through the valid/ready input channel. A local predictor computes the
// writeback, branch and exception fields of every accepted transfer. Results
// are checked in order against those predictions, field by field, while
// both channels idle and stall at random. A short directed set of
// instructions covers every operation and its corner cases, and a long
// random stream follows.
// ----------------------------------------------------------------------------
module integer_execute_unit_test;
  import ieu_pkg::*;

  // With no transfer on either channel for this many cycles the run is hung.
  localparam int STALL_LIMIT  = 400;
  // Pipeline depth plus margin, waited out once nothing is outstanding.
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_ITEMS = 1200;

  typedef enum int {IDLE_NONE, IDLE_BUSY, IDLE_SPARSE} idle_mode_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] in_instruction;
  logic [31:0] in_source_value;
  logic [31:0] in_target_value;
  logic [31:0] in_next_pc;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_result_value;
  logic [4:0]  out_dest_register;
  logic        out_write_enable;
  logic [2:0]  out_exception_code;
  logic        out_branch_taken;
  logic [31:0] out_branch_target;

  // Predicted results of accepted instructions, oldest first.
  ieu_result_t pending_results[$];
  int          error_count = 0;
  int          quiet_cycles = 0;
  idle_mode_t  sender_mode = IDLE_NONE;
  idle_mode_t  receiver_mode = IDLE_NONE;

  integer_execute_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_instruction     (in_instruction),
    .in_source_value    (in_source_value),
    .in_target_value    (in_target_value),
    .in_next_pc         (in_next_pc),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_result_value   (out_result_value),
    .out_dest_register  (out_dest_register),
    .out_write_enable   (out_write_enable),
    .out_exception_code (out_exception_code),
    .out_branch_taken   (out_branch_taken),
    .out_branch_target  (out_branch_target)
  );

  always #4 clk = ~clk;

  // Computes the result of one instruction from its operands.
  function automatic ieu_result_t predict_result(input logic [31:0] instr,
                                                 input logic [31:0] rs_val,
                                                 input logic [31:0] rt_val,
                                                 input logic [31:0] slot_pc);
    ieu_result_t res;
    logic [5:0]  opcode;
    logic [5:0]  funct;
    logic [4:0]  rt_field;
    logic [4:0]  rd_field;
    logic [4:0]  shamt;
    logic [4:0]  selector;
    logic [4:0]  dest;
    logic [15:0] imm;
    logic [31:0] simm;
    logic [31:0] link_addr;
    logic [31:0] branch_addr;
    logic [31:0] sum;
    logic [31:0] wb_val;
    logic [31:0] target;
    logic        wr;
    logic        taken;
    ieu_exc_t    exc;
    opcode      = instr[31:26];
    rt_field    = instr[20:16];
    rd_field    = instr[15:11];
    shamt       = instr[10:6];
    funct       = instr[5:0];
    imm         = instr[15:0];
    simm        = {{16{imm[15]}}, imm};
    link_addr   = slot_pc + 32'd4;
    branch_addr = slot_pc + {simm[29:0], 2'b00};
    wb_val      = '0;
    dest        = '0;
    target      = '0;
    wr          = 1'b0;
    taken       = 1'b0;
    exc         = EXC_NONE;
    case (opcode)
      OP_SPECIAL: begin
        dest = rd_field;
        wr   = 1'b1;
        case (funct)
          FN_SLL:  wb_val = rt_val << shamt;
          FN_SRL:  wb_val = rt_val >> shamt;
          FN_SRA:  wb_val = $signed(rt_val) >>> shamt;
          FN_SLLV: wb_val = rt_val << rs_val[4:0];
          FN_SRLV: wb_val = rt_val >> rs_val[4:0];
          FN_SRAV: wb_val = $signed(rt_val) >>> rs_val[4:0];
          FN_JR: begin
            wr     = 1'b0;
            taken  = 1'b1;
            target = rs_val;
          end
          FN_JALR: begin
            wb_val = link_addr;
            taken  = 1'b1;
            target = rs_val;
          end
          FN_SYSCALL: begin
            wr  = 1'b0;
            exc = EXC_SYSCALL;
          end
          FN_BREAK: begin
            wr  = 1'b0;
            exc = EXC_BREAK;
          end
          FN_ADD: begin
            sum = rs_val + rt_val;
            if (rs_val[31] == rt_val[31] && sum[31] != rs_val[31]) begin
              wr  = 1'b0;
              exc = EXC_OVERFLOW;
            end else begin
              wb_val = sum;
            end
          end
          FN_ADDU: wb_val = rs_val + rt_val;
          FN_SUB: begin
            sum = rs_val - rt_val;
            if (rs_val[31] != rt_val[31] && sum[31] != rs_val[31]) begin
              wr  = 1'b0;
              exc = EXC_OVERFLOW;
            end else begin
              wb_val = sum;
            end
          end
          FN_SUBU: wb_val = rs_val - rt_val;
          FN_AND:  wb_val = rs_val & rt_val;
          FN_OR:   wb_val = rs_val | rt_val;
          FN_XOR:  wb_val = rs_val ^ rt_val;
          FN_NOR:  wb_val = ~(rs_val | rt_val);
          FN_SLT:  wb_val = {31'd0, $signed(rs_val) < $signed(rt_val)};
          FN_SLTU: wb_val = {31'd0, rs_val < rt_val};
          default: begin
            wr  = 1'b0;
            exc = EXC_UNHANDLED;
          end
        endcase
      end
      OP_REGIMM: begin
        // Only the two link selectors are decoded fully; every other value
        // falls back to its low bit.
        selector = rt_field;
        if (selector != RT_BLTZAL && selector != RT_BGEZAL) begin
          selector = {4'd0, selector[0]};
        end
        taken  = selector[0] ? !rs_val[31] : rs_val[31];
        target = branch_addr;
        if (selector[4]) begin
          wr     = 1'b1;
          dest   = RETURN_ADDR_REG;
          wb_val = link_addr;
        end
      end
      OP_J: begin
        taken  = 1'b1;
        target = {slot_pc[31:28], instr[25:0], 2'b00};
      end
      OP_JAL: begin
        taken  = 1'b1;
        target = {slot_pc[31:28], instr[25:0], 2'b00};
        wr     = 1'b1;
        dest   = RETURN_ADDR_REG;
        wb_val = link_addr;
      end
      OP_BEQ: begin
        taken  = (rs_val == rt_val);
        target = branch_addr;
      end
      OP_BNE: begin
        taken  = (rs_val != rt_val);
        target = branch_addr;
      end
      OP_BLEZ: begin
        taken  = (rs_val == 32'd0) || rs_val[31];
        target = branch_addr;
      end
      OP_BGTZ: begin
        taken  = (rs_val != 32'd0) && !rs_val[31];
        target = branch_addr;
      end
      OP_ADDI: begin
        sum = rs_val + simm;
        if (rs_val[31] == simm[31] && sum[31] != rs_val[31]) begin
          exc = EXC_OVERFLOW;
        end else begin
          wr     = 1'b1;
          dest   = rt_field;
          wb_val = sum;
        end
      end
      OP_ADDIU, OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI, OP_XORI, OP_LUI: begin
        wr   = 1'b1;
        dest = rt_field;
        case (opcode)
          OP_ADDIU: wb_val = rs_val + simm;
          OP_SLTI:  wb_val = {31'd0, $signed(rs_val) < $signed(simm)};
          OP_SLTIU: wb_val = {31'd0, rs_val < simm};
          OP_ANDI:  wb_val = rs_val & {16'd0, imm};
          OP_ORI:   wb_val = rs_val | {16'd0, imm};
          OP_XORI:  wb_val = rs_val ^ {16'd0, imm};
          default:  wb_val = {imm, 16'd0};
        endcase
      end
      default: exc = EXC_UNHANDLED;
    endcase
    // Nothing written means value and destination read as zero, and a branch
    // not taken has no target.
    if (!wr || dest == 5'd0) begin
      wr     = 1'b0;
      dest   = '0;
      wb_val = '0;
    end
    if (!taken) begin
      target = '0;
    end
    res.result_value   = wb_val;
    res.dest_register  = dest;
    res.write_enable   = wr;
    res.exception_code = exc;
    res.branch_taken   = taken;
    res.branch_target  = target;
    return res;
  endfunction

  function automatic int draw_wait(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: return 0;
      IDLE_BUSY: return $urandom_range(0, 12);
      default:   return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 12) : 0;
    endcase
  endfunction

  function automatic logic [31:0] enc_special(input logic [5:0] funct,
                                              input logic [4:0] rd,
                                              input logic [4:0] shamt);
    return {OP_SPECIAL, 5'd1, 5'd2, rd, shamt, funct};
  endfunction

  function automatic logic [31:0] enc_imm(input logic [5:0] opcode,
                                          input logic [4:0] rt,
                                          input logic [15:0] imm);
    return {opcode, 5'd3, rt, imm};
  endfunction

  function automatic logic [31:0] enc_jump(input logic [5:0] opcode,
                                           input logic [25:0] index);
    return {opcode, index};
  endfunction

  // Operand values lean toward the sign and carry boundaries.
  function automatic logic [31:0] random_operand();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 5))
          0:       return 32'h0000_0000;
          1:       return 32'h7FFF_FFFF;
          2:       return 32'h8000_0000;
          3:       return 32'hFFFF_FFFF;
          4:       return 32'hFFFF_FFFC;
          default: return 32'h0000_0001;
        endcase
      end
      1:       return $urandom_range(0, 40);
      2:       return 32'hFFFF_FFFF - $urandom_range(0, 40);
      default: return $urandom();
    endcase
  endfunction

  // Mostly decodable instructions with random fields, plus raw noise words.
  function automatic logic [31:0] random_instruction();
    logic [31:0] word;
    word = $urandom();
    case ($urandom_range(0, 11))
      0, 1, 2, 3: begin
        word[31:26] = OP_SPECIAL;
        case ($urandom_range(0, 19))
          0:       word[5:0] = FN_SLL;
          1:       word[5:0] = FN_SRL;
          2:       word[5:0] = FN_SRA;
          3:       word[5:0] = FN_SLLV;
          4:       word[5:0] = FN_SRLV;
          5:       word[5:0] = FN_SRAV;
          6:       word[5:0] = FN_JR;
          7:       word[5:0] = FN_JALR;
          8:       word[5:0] = FN_SYSCALL;
          9:       word[5:0] = FN_BREAK;
          10:      word[5:0] = FN_ADD;
          11:      word[5:0] = FN_ADDU;
          12:      word[5:0] = FN_SUB;
          13:      word[5:0] = FN_SUBU;
          14:      word[5:0] = FN_AND;
          15:      word[5:0] = FN_OR;
          16:      word[5:0] = FN_XOR;
          17:      word[5:0] = FN_NOR;
          18:      word[5:0] = FN_SLT;
          default: word[5:0] = FN_SLTU;
        endcase
      end
      4: begin
        word[31:26] = OP_REGIMM;
        if ($urandom_range(0, 1) == 0) begin
          word[20:16] = 5'($urandom_range(RT_BLTZAL, RT_BGEZAL));
        end
      end
      5:       word[31:26] = 6'($urandom_range(OP_J, OP_BGTZ));
      6, 7, 8: word[31:26] = 6'($urandom_range(OP_ADDI, OP_LUI));
      // Random function codes exercise the reserved SPECIAL slots.
      9:       word[31:26] = OP_SPECIAL;
      default: ;
    endcase
    return word;
  endfunction

  // Presents one instruction after a random gap and records its prediction
  // at the edge of its transfer. Valid is left high so a back-to-back item
  // follows without a dip.
  task automatic send_instruction(input logic [31:0] instr,
                                  input logic [31:0] rs_val,
                                  input logic [31:0] rt_val,
                                  input logic [31:0] slot_pc);
    int gap;
    gap = draw_wait(sender_mode);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_instruction  <= instr;
    in_source_value <= rs_val;
    in_target_value <= rt_val;
    in_next_pc      <= slot_pc;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(predict_result(instr, rs_val, rt_val, slot_pc));
  endtask

  task automatic compare_field(input string field, input logic [31:0] expected,
                               input logic [31:0] actual);
    if (actual !== expected) begin
      $display("%0t: %s expected %h, got %h", $time, field, expected, actual);
      error_count++;
    end
  endtask

  task automatic test_shifts();
    sender_mode   = IDLE_NONE;
    receiver_mode = IDLE_NONE;
    send_instruction(enc_special(FN_SLL, 5'd5, 5'd31), 32'h0, 32'h8000_0001, 32'h100);
    send_instruction(enc_special(FN_SRL, 5'd6, 5'd0), 32'h0, 32'hFFFF_FFFF, 32'h104);
    send_instruction(enc_special(FN_SRA, 5'd7, 5'd31), 32'h0, 32'h8000_0000, 32'h108);
    // Variable shifts use only the low five bits of the source value.
    send_instruction(enc_special(FN_SLLV, 5'd8, 5'd0), 32'hFFFF_FFE1, 32'h8000_0001,
                     32'h10C);
    send_instruction(enc_special(FN_SRLV, 5'd9, 5'd0), 32'h0000_001F, 32'hFFFF_FFFF,
                     32'h110);
    send_instruction(enc_special(FN_SRAV, 5'd31, 5'd0), 32'h0000_0020, 32'h8000_0000,
                     32'h114);
  endtask

  task automatic test_add_subtract();
    sender_mode   = IDLE_BUSY;
    receiver_mode = IDLE_NONE;
    // Signed overflow suppresses the write and raises the overflow code.
    send_instruction(enc_special(FN_ADD, 5'd4, 5'd0), 32'h7FFF_FFFF, 32'h1, 32'h0);
    send_instruction(enc_special(FN_ADDU, 5'd4, 5'd0), 32'hFFFF_FFFF, 32'h1, 32'h0);
    send_instruction(enc_special(FN_SUB, 5'd4, 5'd0), 32'h8000_0000, 32'h1, 32'h0);
    send_instruction(enc_special(FN_SUBU, 5'd4, 5'd0), 32'h0, 32'h1, 32'h0);
    send_instruction(enc_imm(OP_ADDI, 5'd2, 16'h8000), 32'h8000_0000, 32'h0, 32'h0);
    send_instruction(enc_imm(OP_ADDIU, 5'd2, 16'hFFFF), 32'h0, 32'h0, 32'h0);
  endtask

  task automatic test_logic_compare();
    sender_mode   = IDLE_NONE;
    receiver_mode = IDLE_BUSY;
    send_instruction(enc_special(FN_AND, 5'd10, 5'd0), 32'hF0F0_F0F0, 32'hFF00_FF00, 32'h0);
    send_instruction(enc_special(FN_OR, 5'd11, 5'd0), 32'hF0F0_F0F0, 32'h0F0F_0F0F, 32'h0);
    send_instruction(enc_special(FN_XOR, 5'd12, 5'd0), 32'hFFFF_FFFF, 32'hAAAA_5555, 32'h0);
    send_instruction(enc_special(FN_NOR, 5'd13, 5'd0), 32'h0, 32'h0, 32'h0);
    send_instruction(enc_special(FN_SLT, 5'd14, 5'd0), 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
    send_instruction(enc_special(FN_SLTU, 5'd15, 5'd0), 32'h8000_0000, 32'h7FFF_FFFF,
                     32'h0);
    // The unsigned immediate compare still sign-extends its immediate.
    send_instruction(enc_imm(OP_SLTI, 5'd16, 16'hFFFF), 32'hFFFF_FFFE, 32'h0, 32'h0);
    send_instruction(enc_imm(OP_SLTIU, 5'd17, 16'hFFFF), 32'hFFFF_FFFE, 32'h0, 32'h0);
    send_instruction(enc_imm(OP_ANDI, 5'd18, 16'hFFFF), 32'hFFFF_FFFF, 32'h0, 32'h0);
    send_instruction(enc_imm(OP_ORI, 5'd19, 16'h8001), 32'h1234_0000, 32'h0, 32'h0);
    send_instruction(enc_imm(OP_XORI, 5'd20, 16'hFFFF), 32'hFFFF_0000, 32'h0, 32'h0);
    send_instruction(enc_imm(OP_LUI, 5'd21, 16'hFFFF), 32'h0, 32'h0, 32'h0);
  endtask

  task automatic test_branches_jumps();
    sender_mode   = IDLE_SPARSE;
    receiver_mode = IDLE_SPARSE;
    // Branch targets wrap forward past the top and backward below zero.
    send_instruction(enc_imm(OP_BEQ, 5'd0, 16'h0010), 32'h5, 32'h5, 32'hFFFF_FFF0);
    send_instruction(enc_imm(OP_BNE, 5'd0, 16'h8000), 32'h5, 32'h6, 32'h0000_0004);
    send_instruction(enc_imm(OP_BLEZ, 5'd0, 16'h0001), 32'h0, 32'h0, 32'h200);
    send_instruction(enc_imm(OP_BGTZ, 5'd0, 16'h0001), 32'h8000_0000, 32'h0, 32'h200);
    // The link selectors write the return address even when not taken.
    send_instruction(enc_imm(OP_REGIMM, RT_BLTZAL, 16'h0004), 32'h1, 32'h0, 32'h300);
    send_instruction(enc_imm(OP_REGIMM, RT_BGEZAL, 16'hFFFC), 32'h0, 32'h0, 32'hFFFF_FFFC);
    // Other selectors with bit 4 set are plain branches decided by bit 0.
    send_instruction(enc_imm(OP_REGIMM, 5'h12, 16'h0004), 32'h8000_0000, 32'h0, 32'h300);
    send_instruction(enc_imm(OP_REGIMM, 5'h1F, 16'h0004), 32'h8000_0000, 32'h0, 32'h300);
    send_instruction(enc_jump(OP_J, 26'h3FF_FFFF), 32'h0, 32'h0, 32'hF000_0000);
    send_instruction(enc_jump(OP_JAL, 26'h0), 32'h0, 32'h0, 32'hFFFF_FFFC);
    send_instruction(enc_special(FN_JR, 5'd0, 5'd0), 32'hDEAD_BEEF, 32'h0, 32'h400);
    send_instruction(enc_special(FN_JALR, 5'd31, 5'd0), 32'hFFFF_FFFF, 32'h0, 32'h400);
  endtask

  task automatic test_exceptions();
    sender_mode   = IDLE_BUSY;
    receiver_mode = IDLE_BUSY;
    send_instruction(enc_special(FN_SYSCALL, 5'd3, 5'd0), 32'h0, 32'h0, 32'h0);
    send_instruction(enc_special(FN_BREAK, 5'd3, 5'd0), 32'h0, 32'h0, 32'h0);
    // A reserved function code, a load opcode and a write to register zero.
    send_instruction(enc_special(6'h3F, 5'd3, 5'd0), 32'h0, 32'h0, 32'h0);
    send_instruction(enc_imm(6'h23, 5'd3, 16'h0), 32'h0, 32'h0, 32'h0);
    send_instruction(enc_special(FN_ADDU, 5'd0, 5'd0), 32'h1, 32'h2, 32'h0);
  endtask

  task automatic test_random_stream(input int count);
    logic [31:0] rs_val;
    logic [31:0] rt_val;
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) begin
        sender_mode   = idle_mode_t'($urandom_range(0, 2));
        receiver_mode = idle_mode_t'($urandom_range(0, 2));
      end
      rs_val = random_operand();
      // Equal operands give the equality branches a fair chance.
      rt_val = ($urandom_range(0, 3) == 0) ? rs_val : random_operand();
      send_instruction(random_instruction(), rs_val, rt_val, random_operand());
    end
  endtask

  // Result side: stall a random number of cycles before each transfer.
  initial begin
    int stall;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = draw_wait(receiver_mode);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Every result transfer is checked against the oldest prediction.
  always @(posedge clk) begin : check_result
    ieu_result_t expected;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result transfer with no instruction outstanding", $time);
        error_count++;
      end else begin
        expected = pending_results.pop_front();
        compare_field("result_value", expected.result_value, out_result_value);
        compare_field("dest_register", 32'(expected.dest_register),
                      32'(out_dest_register));
        compare_field("write_enable", 32'(expected.write_enable),
                      32'(out_write_enable));
        compare_field("exception_code", 32'(expected.exception_code),
                      32'(out_exception_code));
        compare_field("branch_taken", 32'(expected.branch_taken),
                      32'(out_branch_taken));
        compare_field("branch_target", expected.branch_target, out_branch_target);
      end
    end
  end

  // A run with no transfer on either side for too long has hung.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_instruction  <= '0;
    in_source_value <= '0;
    in_target_value <= '0;
    in_next_pc      <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_shifts();
    test_add_subtract();
    test_logic_compare();
    test_branches_jumps();
    test_exceptions();
    test_random_stream(RANDOM_ITEMS);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
